// ===== hdl/bfbp_pkg.sv =====
`default_nettype none

package bfbp_pkg;

  // Number of bins the storage can hold.
  localparam int MAX_BINS = 64;

  // Bin address width and the width of a count that can hold MAX_BINS itself.
  localparam int BIN_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int CNT_W = $clog2(MAX_BINS + 1);

  localparam int SIZE_W     = 16;
  localparam int IDX_OUT_W  = 6;
  localparam int USED_OUT_W = 7;
  localparam int STATUS_W   = 2;

  localparam logic [CNT_W-1:0]  MAX_BINS_CNT = CNT_W'(MAX_BINS);
  localparam logic [SIZE_W-1:0] CAP_RESET    = 16'd100;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_PLACED   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERSIZE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_BIN   = 2'd2;

  typedef logic [SIZE_W-1:0] size_t;

  // Requests from the scan controller to the bin storage.
  typedef struct packed {
    logic             rd_en;
    logic [BIN_W-1:0] rd_addr;
    logic             wr_en;
    logic [BIN_W-1:0] wr_addr;
    size_t            wr_data;
  } mem_req_t;

  // One finished result.
  typedef struct packed {
    logic [IDX_OUT_W-1:0]  bin_index;
    logic                  opened_new_bin;
    logic [USED_OUT_W-1:0] bins_used;
    logic [STATUS_W-1:0]   status;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/bfbp_bin_mem.sv =====
`default_nettype none

module bfbp_bin_mem (
  input  logic                        clk,
  input  bfbp_pkg::mem_req_t          req,
  output logic [bfbp_pkg::SIZE_W-1:0] rd_data
);
  import bfbp_pkg::*;

  // Remaining space of each bin; one write and one registered read per cycle.
  size_t bin_rem_r [MAX_BINS];
  size_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      bin_rem_r[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= bin_rem_r[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hdl/bfbp_scan_ctrl.sv =====
`default_nettype none

module bfbp_scan_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        item_accept,
  input  logic [bfbp_pkg::SIZE_W-1:0] item_size,
  input  logic                        item_clear,
  input  logic [bfbp_pkg::SIZE_W-1:0] capacity,
  input  logic [bfbp_pkg::SIZE_W-1:0] rd_data,
  input  logic                        res_take,
  output logic                        idle,
  output bfbp_pkg::mem_req_t          mem_req,
  output logic                        res_valid,
  output bfbp_pkg::result_t           result
);
  import bfbp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t           state_r,     state_nxt;
  size_t            size_r,      size_nxt;
  logic [CNT_W-1:0] cnt_r,       cnt_nxt;
  logic [CNT_W-1:0] rd_idx_r,    rd_idx_nxt;
  logic             pend_r,      pend_nxt;
  logic [BIN_W-1:0] pend_idx_r,  pend_idx_nxt;
  logic             found_r,     found_nxt;
  size_t            best_left_r, best_left_nxt;
  logic [BIN_W-1:0] best_idx_r,  best_idx_nxt;
  result_t          res_r,       res_nxt;

  logic  fit;
  logic  better;
  size_t left;

  // Compare stage: the read issued last cycle returns one bin's remaining space.
  assign fit    = pend_r && (rd_data >= size_r);
  assign left   = rd_data - size_r;
  assign better = fit && (!found_r || (left < best_left_r));

  always_comb begin
    state_nxt     = state_r;
    size_nxt      = size_r;
    cnt_nxt       = cnt_r;
    rd_idx_nxt    = rd_idx_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    found_nxt     = found_r;
    best_left_nxt = best_left_r;
    best_idx_nxt  = best_idx_r;
    res_nxt       = res_r;
    mem_req       = '0;
    mem_req.rd_addr = rd_idx_r[BIN_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (item_accept) begin
          size_nxt   = item_size;
          cnt_nxt    = item_clear ? '0 : cnt_r;
          rd_idx_nxt = '0;
          pend_nxt   = 1'b0;
          found_nxt  = 1'b0;
          if (item_size > capacity) begin
            res_nxt.bin_index      = '0;
            res_nxt.opened_new_bin = 1'b0;
            res_nxt.bins_used      = USED_OUT_W'(cnt_nxt);
            res_nxt.status         = ST_OVERSIZE;
            state_nxt              = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (better) begin
          found_nxt     = 1'b1;
          best_left_nxt = left;
          best_idx_nxt  = pend_idx_r;
        end
        if (rd_idx_r < cnt_r) begin
          mem_req.rd_en = 1'b1;
          rd_idx_nxt    = rd_idx_r + 1'b1;
          pend_nxt      = 1'b1;
          pend_idx_nxt  = rd_idx_r[BIN_W-1:0];
        end else begin
          pend_nxt = 1'b0;
          // All reads compared: update the chosen bin, open one or flag no bin.
          if (!pend_r) begin
            state_nxt = S_DONE;
            if (found_r) begin
              mem_req.wr_en          = 1'b1;
              mem_req.wr_addr        = best_idx_r;
              mem_req.wr_data        = best_left_r;
              res_nxt.bin_index      = IDX_OUT_W'(best_idx_r);
              res_nxt.opened_new_bin = 1'b0;
              res_nxt.bins_used      = USED_OUT_W'(cnt_r);
              res_nxt.status         = ST_PLACED;
            end else if (cnt_r < MAX_BINS_CNT) begin
              mem_req.wr_en          = 1'b1;
              mem_req.wr_addr        = cnt_r[BIN_W-1:0];
              mem_req.wr_data        = capacity - size_r;
              cnt_nxt                = cnt_r + 1'b1;
              res_nxt.bin_index      = IDX_OUT_W'(cnt_r);
              res_nxt.opened_new_bin = 1'b1;
              res_nxt.bins_used      = USED_OUT_W'(cnt_nxt);
              res_nxt.status         = ST_PLACED;
            end else begin
              res_nxt.bin_index      = '0;
              res_nxt.opened_new_bin = 1'b0;
              res_nxt.bins_used      = USED_OUT_W'(cnt_r);
              res_nxt.status         = ST_NO_BIN;
            end
          end
        end
      end

      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      rd_idx_r <= '0;
      pend_r   <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      rd_idx_r <= rd_idx_nxt;
      pend_r   <= pend_nxt;
      found_r  <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r      <= size_nxt;
    pend_idx_r  <= pend_idx_nxt;
    best_left_r <= best_left_nxt;
    best_idx_r  <= best_idx_nxt;
    res_r       <= res_nxt;
  end

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign result    = res_r;

endmodule

`default_nettype wire

// ===== hdl/best_fit_bin_packer.sv =====
`default_nettype none

// Online best-fit bin packer. Each transfer on the input channel carries one
// item size and a flag that empties all bins before the item is placed; each
// item gives exactly one result transfer with the bin that took it, whether a
// new bin was opened, the number of open bins and a status (placed, item
// larger than the capacity, or no bin left). The remaining space of every bin
// sits in a 64-entry synchronous memory; the controller reads the open bins
// one per cycle through its single read port, keeps the best fit (lowest index
// on a tie) and writes the chosen entry back. The next item is taken only
// once the controller has handed the last result on; an oversized item skips
// the scan. A finished result waits in an output register, so the next item
// is taken while it is still stalled.
// The capacity register (reset value 100) is written through the cfg port and
// must only be changed while no item is in flight.
module best_fit_bin_packer (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bfbp_pkg::SIZE_W-1:0]     in_item_size,
  input  logic                            in_start_new_set,

  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bfbp_pkg::IDX_OUT_W-1:0]  out_bin_index,
  output logic                            out_opened_new_bin,
  output logic [bfbp_pkg::USED_OUT_W-1:0] out_bins_used,
  output logic [bfbp_pkg::STATUS_W-1:0]   out_status,

  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bfbp_pkg::SIZE_W-1:0]     cfg_bin_capacity
);
  import bfbp_pkg::*;

  size_t    cap_r;
  logic     ctrl_idle;
  logic     res_valid;
  logic     res_take;
  result_t  result;
  mem_req_t mem_req;
  size_t    rd_data;
  logic     out_valid_r;
  result_t  out_res_r;

  // Every write is taken; users must write only while idle (not enforced).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_bin_capacity;
    end
  end

  // A new item is taken whenever the controller has handed off its last result.
  assign in_stall = !ctrl_idle;

  bfbp_scan_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_accept (in_valid && !in_stall),
    .item_size   (in_item_size),
    .item_clear  (in_start_new_set),
    .capacity    (cap_r),
    .rd_data     (rd_data),
    .res_take    (res_take),
    .idle        (ctrl_idle),
    .mem_req     (mem_req),
    .res_valid   (res_valid),
    .result      (result)
  );

  bfbp_bin_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // Output register: loads when empty or when its current result transfers.
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= result;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_bin_index      = out_res_r.bin_index;
  assign out_opened_new_bin = out_res_r.opened_new_bin;
  assign out_bins_used      = out_res_r.bins_used;
  assign out_status         = out_res_r.status;

  // An accepted item keeps the controller busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item accepted twice in a row");

  // A rejected item never names a bin or opens one.
  a_reject_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_PLACED)) |->
      ((out_bin_index == '0) && !out_opened_new_bin))
    else $error("rejected item carries a bin");

  // A freshly opened bin is always the highest open one.
  a_new_bin_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_opened_new_bin) |->
      ((out_status == ST_PLACED) &&
       (out_bin_index == IDX_OUT_W'(out_bins_used - 1'b1))))
    else $error("new bin index does not match bin count");

endmodule

`default_nettype wire

// ===== sim/tb_best_fit_bin_packer.sv =====
`timescale 1ns / 1ps

// Testbench for the best-fit bin packer.
//
// Items are sent one transfer at a time through send_item, which also runs
// every accepted item through a behavioral model of the packer. The model
// keeps its own copy of the remaining space per bin, the open bin count and
// the capacity register. Its prediction is queued. An independent checker
// pops the oldest prediction for every result transfer and compares it field
// by field. The capacity register is only rewritten after all results have
// come back and the block has had time to finish any scan in progress.
//
// Both handshakes are driven on the falling edge and sampled on the rising
// edge. The sender inserts random gaps and the receiver stalls at random.
// The rates change from one traffic phase to the next. One test holds the
// receiver off for a long stretch so that the output register fills and the
// block pushes back on its input.
module tb_best_fit_bin_packer;
  import bfbp_pkg::*;

  localparam int CLK_HALF       = 5;
  // Long enough for a scan of all MAX_BINS entries and the update that follows.
  localparam int SCAN_LATENCY   = MAX_BINS + 8;
  // Cycles without any transfer before the run is declared hung. This covers
  // the long receiver hold-off plus a full-depth scan with a wide margin.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_OFF_LEN   = 400;

  typedef struct {
    result_t res;
    int      item_no;
  } placement_exp_t;

  logic                  clk;
  logic                  rst_n;

  logic                  in_valid;
  logic                  in_stall;
  logic [SIZE_W-1:0]     in_item_size;
  logic                  in_start_new_set;

  logic                  out_valid;
  logic                  out_stall;
  logic [IDX_OUT_W-1:0]  out_bin_index;
  logic                  out_opened_new_bin;
  logic [USED_OUT_W-1:0] out_bins_used;
  logic [STATUS_W-1:0]   out_status;

  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [SIZE_W-1:0]     cfg_bin_capacity;

  // Behavioral copy of the packer state.
  logic [SIZE_W-1:0]     bin_space [MAX_BINS];
  int                    open_bins;
  logic [SIZE_W-1:0]     bin_capacity_now;

  placement_exp_t        pending_placements[$];
  int                    items_sent;
  int                    mismatch_count;

  // Idling controls, shared between the stimulus and the receiver.
  int                    send_idle_pct;
  int                    recv_stall_pct;
  int                    stall_hold_cycles;

  int                    quiet_cycles;

  best_fit_bin_packer uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_item_size       (in_item_size),
    .in_start_new_set   (in_start_new_set),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_bin_index      (out_bin_index),
    .out_opened_new_bin (out_opened_new_bin),
    .out_bins_used      (out_bins_used),
    .out_status         (out_status),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_bin_capacity   (cfg_bin_capacity)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Best-fit placement of one item against the model state. The start flag
  // empties the bins first, even for an item that is then rejected.
  function automatic result_t predict_placement(input logic [SIZE_W-1:0] size,
                                                input logic start);
    result_t r;
    bit      found;
    int      best_left;
    int      chosen;
    int      k;
    r = '0;
    r.status = ST_PLACED;
    found = 1'b0;
    best_left = 0;
    chosen = 0;
    if (start) begin
      open_bins = 0;
    end
    if (size > bin_capacity_now) begin
      r.status = ST_OVERSIZE;
    end else begin
      // Strictly-less keeps the lowest index on a tie.
      for (k = 0; k < open_bins; k++) begin
        if (int'(bin_space[k]) >= int'(size) &&
            (!found || int'(bin_space[k]) - int'(size) < best_left)) begin
          found = 1'b1;
          best_left = int'(bin_space[k]) - int'(size);
          chosen = k;
        end
      end
      if (found) begin
        bin_space[chosen] = SIZE_W'(best_left);
      end else if (open_bins < MAX_BINS) begin
        chosen = open_bins;
        bin_space[chosen] = bin_capacity_now - size;
        open_bins++;
        r.opened_new_bin = 1'b1;
      end else begin
        r.status = ST_NO_BIN;
      end
    end
    // When the item is rejected, chosen is still 0, so the index reads 0.
    r.bin_index = IDX_OUT_W'(chosen);
    r.bins_used = USED_OUT_W'(open_bins);
    return r;
  endfunction

  // Mostly sizes that fit, with zero, exact-capacity, oversized and fully
  // random sizes mixed in so that every bit of the field toggles.
  function automatic logic [SIZE_W-1:0] rand_item_size(input logic [SIZE_W-1:0] cap);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      return '0;
    end
    if (pick < 12 && cap != '1) begin
      return SIZE_W'($urandom_range(int'(cap) + 1, 65535));
    end
    if (pick < 18) begin
      return SIZE_W'($urandom);
    end
    if (pick < 28) begin
      return cap;
    end
    return SIZE_W'($urandom_range(1, int'(cap)));
  endfunction

  task automatic report_mismatch(input string field, input int item_no,
                                 input int got, input int want);
    mismatch_count++;
    $display("MISMATCH item %0d %s: got %0d, expected %0d at %0t",
             item_no, field, got, want, $realtime);
  endtask

  // Offers one item and holds it until the block takes it. The prediction
  // is made at the accepting edge, so it sees the state left by all earlier
  // items. Valid stays high on return until the next call or the drain.
  task automatic send_item(input logic [SIZE_W-1:0] size, input logic start);
    placement_exp_t entry;
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_item_size = size;
    in_start_new_set = start;
    do @(posedge clk); while (in_stall);
    entry.res = predict_placement(size, start);
    entry.item_no = items_sent;
    pending_placements.push_back(entry);
    items_sent++;
  endtask

  // Drops the input valid, then waits until every predicted result has
  // been collected and any scan in progress has run out.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_placements.size() != 0) @(posedge clk);
    repeat (SCAN_LATENCY) @(posedge clk);
  endtask

  // Capacity is only changed with the block idle.
  task automatic write_capacity(input logic [SIZE_W-1:0] value);
    wait_for_results();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_bin_capacity = value;
    do @(posedge clk); while (!cfg_ready);
    bin_capacity_now = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Hand-picked items at the reset capacity of 100. The sequence covers
  // exact fits, zero-size items with and without a full bin, ties between
  // equally good bins, oversized items and the start flag on a rejected item.
  task automatic test_directed_cases();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_item(16'd0, 1'b1);      // Zero size with no bin open opens one.
    send_item(16'd100, 1'b0);    // Exact fit leaves bin 0 full.
    send_item(16'd0, 1'b0);      // Zero size goes to the lowest full bin.
    send_item(16'd101, 1'b0);    // One over the capacity.
    send_item(16'd60, 1'b0);
    send_item(16'd60, 1'b0);
    send_item(16'd30, 1'b0);     // Bins 1 and 2 tie; bin 1 should win.
    send_item(16'd40, 1'b0);
    send_item(16'd0, 1'b0);
    send_item(16'hFFFF, 1'b1);   // Rejected, but the bins are still emptied.
    send_item(16'd0, 1'b0);
    send_item(16'd1, 1'b1);
    send_item(16'd99, 1'b0);
    send_item(16'd100, 1'b0);
    send_item(16'd50, 1'b1);
    send_item(16'd70, 1'b0);
    send_item(16'd25, 1'b0);     // Best fit is the tighter bin, not the first.
    send_item(16'h8000, 1'b0);
  endtask

  // Largest capacity and the smallest nonzero one.
  task automatic test_capacity_extremes();
    write_capacity(16'hFFFF);
    send_item(16'hFFFF, 1'b1);
    send_item(16'hFFFF, 1'b0);
    send_item(16'd0, 1'b0);
    send_item(16'h5555, 1'b1);
    send_item(16'hAAAA, 1'b0);
    send_item(16'hAAAB, 1'b0);
    write_capacity(16'd1);
    send_item(16'd1, 1'b1);
    send_item(16'd0, 1'b0);
    send_item(16'd2, 1'b0);
    send_item(16'd1, 1'b0);
  endtask

  // Long sets without a start flag run every bin up to the last index and
  // then hit the no-bin-left case. Zero and small items keep landing in
  // leftover space after that.
  task automatic test_bin_exhaustion();
    int n;
    write_capacity(16'd3);
    send_idle_pct = 10;
    recv_stall_pct = 10;
    send_item(16'd3, 1'b1);
    for (n = 0; n < 90; n++) begin
      if ($urandom_range(0, 99) < 80) begin
        send_item(SIZE_W'($urandom_range(2, 3)), 1'b0);
      end else begin
        send_item(SIZE_W'($urandom_range(0, 3)), 1'b0);
      end
    end
    write_capacity(16'd1);
    send_item(16'd1, 1'b1);
    for (n = 0; n < 70; n++) begin
      send_item(($urandom_range(0, 9) == 0) ? 16'd0 : 16'd1, 1'b0);
    end
  endtask

  // The receiver refuses results for a long stretch while items keep coming.
  // The block has room for one finished result and one in progress, so it
  // must push back on the input until the receiver lets go.
  task automatic test_output_backpressure();
    int n;
    write_capacity(16'd100);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    stall_hold_cycles = HOLD_OFF_LEN;
    send_item(rand_item_size(bin_capacity_now), 1'b1);
    for (n = 0; n < 14; n++) begin
      send_item(rand_item_size(bin_capacity_now), 1'b0);
    end
  endtask

  // Random sets of items under one capacity and one idling mix. Every phase
  // opens with a start flag, and further sets begin now and then.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int count, input logic [SIZE_W-1:0] cap);
    int n;
    write_capacity(cap);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    send_item(rand_item_size(cap), 1'b1);
    for (n = 1; n < count; n++) begin
      send_item(rand_item_size(cap), $urandom_range(0, 99) < 3);
    end
  endtask

  // Receiver: stalls at random, or solidly while a hold-off is running.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_hold_cycles > 0) begin
        out_stall = 1'b1;
        stall_hold_cycles--;
      end else begin
        out_stall = (recv_stall_pct != 0) && ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // Result checker: every result transfer is matched against the oldest
  // prediction.
  always @(posedge clk) begin
    placement_exp_t exp_entry;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_placements.size() == 0) begin
        report_mismatch("result with no item pending", -1, out_bin_index, 0);
      end else begin
        exp_entry = pending_placements.pop_front();
        if (out_bin_index !== exp_entry.res.bin_index) begin
          report_mismatch("bin_index", exp_entry.item_no, out_bin_index,
                          exp_entry.res.bin_index);
        end
        if (out_opened_new_bin !== exp_entry.res.opened_new_bin) begin
          report_mismatch("opened_new_bin", exp_entry.item_no, out_opened_new_bin,
                          exp_entry.res.opened_new_bin);
        end
        if (out_bins_used !== exp_entry.res.bins_used) begin
          report_mismatch("bins_used", exp_entry.item_no, out_bins_used,
                          exp_entry.res.bins_used);
        end
        if (out_status !== exp_entry.res.status) begin
          report_mismatch("status", exp_entry.item_no, out_status,
                          exp_entry.res.status);
        end
      end
    end
  end

  // Watchdog: any transfer on any channel resets the count of quiet cycles.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL best_fit_bin_packer");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item_size = '0;
    in_start_new_set = 1'b0;
    cfg_valid = 1'b0;
    cfg_bin_capacity = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    stall_hold_cycles = 0;
    quiet_cycles = 0;
    items_sent = 0;
    mismatch_count = 0;
    // Model state after reset. Bin entries are never read before they are
    // written, so their starting value does not matter.
    bin_capacity_now = CAP_RESET;
    open_bins = 0;
    foreach (bin_space[i]) bin_space[i] = '0;

    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_directed_cases();
    test_capacity_extremes();
    test_bin_exhaustion();
    test_output_backpressure();
    test_random_traffic(0, 0, 100, 16'hFFFF);
    test_random_traffic(66, 0, 90, SIZE_W'($urandom_range(2, 30)));
    test_random_traffic(0, 66, 90, SIZE_W'($urandom_range(100, 5000)));
    test_random_traffic(26, 26, 90, SIZE_W'($urandom_range(1, 65535)));

    // Let everything drain, then give the block time to show any stray result.
    wait_for_results();
    if (mismatch_count == 0) begin
      $display("PASS best_fit_bin_packer");
    end else begin
      $display("FAIL best_fit_bin_packer");
    end
    $finish;
  end

endmodule
